FILE: sv/rfs_pkg.sv
// rfs_pkg: shared types and constants for the rx frame store.
// No dependencies; used by rfs_cell and rx_frame_store_oldest_evict_unit.
package rfs_pkg;

  localparam int unsigned DefaultSlots = 16;
  localparam int unsigned IdW          = 11;
  localparam int unsigned LenW         = 4;
  localparam int unsigned PayW         = 64;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned FillW        = 5;
  localparam int unsigned InDataW      = 112;
  localparam int unsigned OutDataW     = 120;

  localparam logic OpStore = 1'b0;
  localparam logic OpFetch = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [PayW-1:0]  payload;
    logic [TimeW-1:0] stamp;
  } frame_t;

  // search token walking down the cell row
  typedef struct packed {
    logic             active;
    logic             op;
    logic             any;
    logic             done;
    frame_t           frame;
    logic             old_seen;
    logic [TimeW-1:0] old_time;
  } carry_t;

endpackage

FILE: sv/rfs_cell.sv
// rfs_cell: one frame slot plus one stage of the search token chain.
// Depends on rfs_pkg.
module rfs_cell #(
  parameter int unsigned SLOTS = rfs_pkg::DefaultSlots,
  parameter int unsigned IDX   = 0,
  localparam int unsigned IdxW = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rfs_pkg::carry_t      carry_in,
  input  logic [IdxW-1:0]      old_idx_in,
  output rfs_pkg::carry_t      carry_out,
  output logic [IdxW-1:0]      old_idx_out,
  input  logic                 wr_en,
  input  logic [IdxW-1:0]      wr_idx,
  input  rfs_pkg::frame_t      wr_frame
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic            valid;
  rfs_pkg::frame_t slot;

  logic            hit_store;
  logic            hit_fetch;
  logic            older;
  logic            evict_wr;
  rfs_pkg::carry_t carry_next;
  logic [IdxW-1:0] old_idx_next;

  always_comb begin
    hit_store = carry_in.active && (carry_in.op == rfs_pkg::OpStore) &&
                !carry_in.done && !valid;
    hit_fetch = carry_in.active && (carry_in.op == rfs_pkg::OpFetch) &&
                !carry_in.done && valid &&
                (carry_in.any || (slot.id == carry_in.frame.id));
    older     = carry_in.active && (carry_in.op == rfs_pkg::OpStore) &&
                !carry_in.done && valid &&
                (!carry_in.old_seen || (slot.stamp < carry_in.old_time));
    evict_wr  = wr_en && (wr_idx == MyIdx);

    carry_next   = carry_in;
    old_idx_next = old_idx_in;
    if (hit_store || hit_fetch) begin
      carry_next.done = 1'b1;
    end
    if (hit_fetch) begin
      carry_next.frame = slot;
    end
    if (older) begin
      carry_next.old_seen = 1'b1;
      carry_next.old_time = slot.stamp;
      old_idx_next        = MyIdx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid            <= 1'b0;
      carry_out.active <= 1'b0;
    end else begin
      if (hit_store || evict_wr) begin
        valid <= 1'b1;
      end else if (hit_fetch) begin
        valid <= 1'b0;
      end
      carry_out <= carry_next;
    end
    if (hit_store) begin
      slot <= carry_in.frame;
    end else if (evict_wr) begin
      slot <= wr_frame;
    end
    old_idx_out <= old_idx_next;
  end

endmodule

FILE: sv/rx_frame_store_oldest_evict_unit.sv
// rx_frame_store_oldest_evict_unit: top level of the received frame slot store.
// Depends on rfs_pkg and rfs_cell.
//
// Holds SLOTS received frames in a row of cells. Each transaction launches a
// search token that visits one cell per clock: a store takes the first free
// cell and a fetch takes and frees the first valid cell whose ID matches (or
// any valid cell with match_any). A store that finds no free cell overwrites
// the cell with the oldest arrival time, lowest index on ties. One transaction
// is in flight at a time: the token walks the cell row, the result is captured
// in WALK, a store that evicts passes through EVICT, and FINISH registers the result.
// A result may wait on m_axis_tready while the next transaction is accepted.
module rx_frame_store_oldest_evict_unit #(
  parameter int unsigned SLOTS = rfs_pkg::DefaultSlots
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // frame_id[10:0], match_any[11], frame_length[15:12],
  // frame_payload[79:16], arrival_time[111:80]
  input  logic [rfs_pkg::InDataW-1:0]   s_axis_tdata,
  // op[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // found[0], out_id[11:1], out_length[15:12], out_payload[79:16],
  // out_time[111:80], evicted[112], fill_level[117:113], zero[119:118]
  output logic [rfs_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {IDLE, WALK, EVICT, FINISH} state_t;

  state_t            state;
  rfs_pkg::carry_t   launch;
  rfs_pkg::carry_t   carry [SLOTS+1];
  logic [IdxW-1:0]   old_idx [SLOTS+1];

  logic              res_op;
  logic              res_done;
  rfs_pkg::frame_t   res_frame;
  logic [IdxW-1:0]   res_idx;
  logic [CntW-1:0]   count;

  logic              in_hs;
  logic              wr_en;
  logic              found;
  logic              evicted;
  rfs_pkg::frame_t   out_frame;
  logic [CntW+rfs_pkg::FillW-1:0] count_wide;
  logic [rfs_pkg::FillW-1:0]      fill;

  assign s_axis_tready = (state == IDLE);
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign wr_en         = (state == EVICT);

  assign carry[0]   = launch;
  assign old_idx[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    rfs_cell #(
      .SLOTS (SLOTS),
      .IDX   (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .carry_in    (carry[k]),
      .old_idx_in  (old_idx[k]),
      .carry_out   (carry[k+1]),
      .old_idx_out (old_idx[k+1]),
      .wr_en       (wr_en),
      .wr_idx      (res_idx),
      .wr_frame    (res_frame)
    );
  end

  always_comb begin
    found      = (res_op == rfs_pkg::OpFetch) && res_done;
    evicted    = (res_op == rfs_pkg::OpStore) && !res_done;
    out_frame  = found ? res_frame : '0;
    count_wide = {{rfs_pkg::FillW{1'b0}}, count};
    if (count_wide > (CntW + rfs_pkg::FillW)'(31)) begin
      fill = '1;
    end else begin
      fill = count_wide[rfs_pkg::FillW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      launch.active <= 1'b0;
      m_axis_tvalid <= 1'b0;
      count         <= '0;
    end else begin
      launch.active <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_hs) begin
            launch.active <= 1'b1;
            state         <= WALK;
          end
        end
        WALK: begin
          if (carry[SLOTS].active) begin
            res_op    <= carry[SLOTS].op;
            res_done  <= carry[SLOTS].done;
            res_frame <= carry[SLOTS].frame;
            res_idx   <= old_idx[SLOTS];
            if (carry[SLOTS].done) begin
              if (carry[SLOTS].op == rfs_pkg::OpStore) begin
                count <= count + CntW'(1);
              end else begin
                count <= count - CntW'(1);
              end
            end
            if ((carry[SLOTS].op == rfs_pkg::OpStore) && !carry[SLOTS].done) begin
              state <= EVICT;
            end else begin
              state <= FINISH;
            end
          end
        end
        EVICT: begin
          state <= FINISH;
        end
        FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, fill, evicted, out_frame.stamp,
                              out_frame.payload, out_frame.len, out_frame.id, found};
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    if (in_hs) begin
      launch.op       <= s_axis_tuser;
      launch.any      <= s_axis_tdata[11];
      launch.done     <= 1'b0;
      launch.frame    <= '{id:      s_axis_tdata[10:0],
                           len:     s_axis_tdata[15:12],
                           payload: s_axis_tdata[79:16],
                           stamp:   s_axis_tdata[111:80]};
      launch.old_seen <= 1'b0;
      launch.old_time <= '0;
    end
  end

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for rx_frame_store_oldest_evict_unit (16-slot frame store).
// Depends on rfs_pkg and the unit; runs directed store/fetch/evict cases, then
// random fill-heavy, drain-heavy and mixed phases, all checked against an in-bench slot model.
module tb;

  localparam int unsigned NSLOTS         = rfs_pkg::DefaultSlots;
  localparam int unsigned RANDOM_ITEMS   = 1025;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                      op;
    logic [rfs_pkg::IdW-1:0]   id;
    logic                      any;
    logic [rfs_pkg::LenW-1:0]  len;
    logic [rfs_pkg::PayW-1:0]  payload;
    logic [rfs_pkg::TimeW-1:0] stamp;
  } request_t;

  typedef struct packed {
    logic                      found;
    logic [rfs_pkg::IdW-1:0]   id;
    logic [rfs_pkg::LenW-1:0]  len;
    logic [rfs_pkg::PayW-1:0]  payload;
    logic [rfs_pkg::TimeW-1:0] stamp;
    logic                      evicted;
    logic [rfs_pkg::FillW-1:0] fill;
  } reply_t;

  logic                         clk           = 1'b0;
  logic                         rst           = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [rfs_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [rfs_pkg::OutDataW-1:0] m_axis_tdata;

  // slot model
  bit                        held       [NSLOTS];
  logic [rfs_pkg::IdW-1:0]   held_id    [NSLOTS];
  logic [rfs_pkg::LenW-1:0]  held_len   [NSLOTS];
  logic [rfs_pkg::PayW-1:0]  held_pay   [NSLOTS];
  logic [rfs_pkg::TimeW-1:0] held_stamp [NSLOTS];

  request_t queued_requests[$];
  reply_t   awaited_replies[$];

  request_t in_flight;
  bit       loaded;
  int       send_wait;
  int       take_wait;
  bit       quiet_in;
  bit       quiet_out;
  int       stuck_cycles;
  int       mismatch_total;
  int       store_total;
  int       evict_total;
  int       fetch_total;
  int       hit_total;

  rx_frame_store_oldest_evict_unit #(.SLOTS(NSLOTS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic request_t store_req(logic [rfs_pkg::IdW-1:0] id,
                                         logic [rfs_pkg::LenW-1:0] len,
                                         logic [rfs_pkg::PayW-1:0] pay,
                                         logic [rfs_pkg::TimeW-1:0] stamp);
    request_t r;
    r.op      = rfs_pkg::OpStore;
    r.id      = id;
    r.any     = 1'b0;
    r.len     = len;
    r.payload = pay;
    r.stamp   = stamp;
    return r;
  endfunction

  function automatic request_t fetch_req(logic [rfs_pkg::IdW-1:0] id, logic any);
    request_t r;
    r.op      = rfs_pkg::OpFetch;
    r.id      = id;
    r.any     = any;
    r.len     = rfs_pkg::LenW'($urandom_range(0, 15));
    r.payload = {$urandom, $urandom};
    r.stamp   = $urandom;
    return r;
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // store: lowest free slot, else oldest stamp (lowest index on ties)
  // fetch: lowest valid slot with matching id (or any), then freed
  function automatic reply_t predict_slot_store(request_t rq);
    reply_t      rp;
    int unsigned pick;
    int unsigned occupied;
    bit          hit;
    rp = '0;
    if (rq.op == rfs_pkg::OpStore) begin
      pick = NSLOTS;
      for (int k = NSLOTS - 1; k >= 0; k--) begin
        if (!held[k]) pick = k;
      end
      if (pick == NSLOTS) begin
        pick = 0;
        for (int k = 1; k < NSLOTS; k++) begin
          if (held_stamp[k] < held_stamp[pick]) pick = k;
        end
        rp.evicted = 1'b1;
      end
      held[pick]       = 1'b1;
      held_id[pick]    = rq.id;
      held_len[pick]   = rq.len;
      held_pay[pick]   = rq.payload;
      held_stamp[pick] = rq.stamp;
    end else begin
      hit = 1'b0;
      for (int k = 0; k < NSLOTS; k++) begin
        if (!hit && held[k] && (rq.any || held_id[k] == rq.id)) begin
          hit        = 1'b1;
          rp.found   = 1'b1;
          rp.id      = held_id[k];
          rp.len     = held_len[k];
          rp.payload = held_pay[k];
          rp.stamp   = held_stamp[k];
          held[k]    = 1'b0;
        end
      end
    end
    occupied = 0;
    for (int k = 0; k < NSLOTS; k++) if (held[k]) occupied++;
    rp.fill = (occupied > 31) ? rfs_pkg::FillW'(31) : rfs_pkg::FillW'(occupied);
    return rp;
  endfunction

  task automatic report_mismatch(string what, reply_t want, reply_t got);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%s: want found=%0b id=%h len=%h pay=%h time=%h evicted=%0b fill=%0d",
               what, want.found, want.id, want.len, want.payload, want.stamp,
               want.evicted, want.fill);
      $display("  got found=%0b id=%h len=%h pay=%h time=%h evicted=%0b fill=%0d",
               got.found, got.id, got.len, got.payload, got.stamp, got.evicted, got.fill);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      loaded = 1'b0;
      send_wait = draw_wait(1'b0);
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_replies.push_back(predict_slot_store(in_flight));
        if (in_flight.op == rfs_pkg::OpStore) begin
          store_total++;
          if (awaited_replies[$].evicted) evict_total++;
        end else begin
          fetch_total++;
          if (awaited_replies[$].found) hit_total++;
        end
        loaded = 1'b0;
        if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
        send_wait = draw_wait(quiet_in);
      end
      if (!loaded) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (queued_requests.size() > 0) begin
          in_flight = queued_requests.pop_front();
          loaded = 1'b1;
          s_axis_tdata <= {in_flight.stamp, in_flight.payload, in_flight.len,
                           in_flight.any, in_flight.id};
          s_axis_tuser <= in_flight.op;
        end
      end
      s_axis_tvalid <= loaded;
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      take_wait = draw_wait(1'b0);
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found   = m_axis_tdata[0];
        got.id      = m_axis_tdata[11:1];
        got.len     = m_axis_tdata[15:12];
        got.payload = m_axis_tdata[79:16];
        got.stamp   = m_axis_tdata[111:80];
        got.evicted = m_axis_tdata[112];
        got.fill    = m_axis_tdata[117:113];
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected transaction", '0, got);
        end else begin
          want = awaited_replies.pop_front();
          if (want !== got) report_mismatch("mismatch", want, got);
        end
        if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
        take_wait = draw_wait(quiet_out);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      m_axis_tready <= (take_wait == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    request_t                  r;
    logic [rfs_pkg::IdW-1:0]   fid;
    logic [rfs_pkg::IdW-1:0]   id_pool [6];
    logic [rfs_pkg::TimeW-1:0] stamp;
    logic [rfs_pkg::TimeW-1:0] stamp_clock;
    logic [rfs_pkg::LenW-1:0]  len;
    logic [rfs_pkg::PayW-1:0]  pay;
    int                        made;
    int                        phase_len;
    int                        store_pct;
    int                        sel;

    // directed: empty fetches, fill with edge values, tied-oldest evictions,
    // id/any fetches, no-match fetch, duplicate ids
    queued_requests.push_back(fetch_req('0, 1'b1));
    queued_requests.push_back(fetch_req('1, 1'b0));
    for (int k = 0; k < NSLOTS; k++) begin
      case (k)
        0:       fid = '0;
        1:       fid = '1;
        4, 5:    fid = 11'h155;
        default: fid = rfs_pkg::IdW'(11'h2A0 + k);
      endcase
      if (k == 3 || k == 7) stamp = 32'd1;
      else if (k == 1)      stamp = '1;
      else                  stamp = rfs_pkg::TimeW'(100 + k);
      if (k == 0)      pay = '0;
      else if (k == 1) pay = '1;
      else             pay = {$urandom, $urandom};
      queued_requests.push_back(store_req(fid, rfs_pkg::LenW'(k), pay, stamp));
    end
    queued_requests.push_back(store_req(11'h3C3, 4'd8, {$urandom, $urandom}, '1));
    queued_requests.push_back(store_req(11'h43C, 4'd0, {$urandom, $urandom}, 32'd2));
    queued_requests.push_back(fetch_req('1, 1'b0));
    queued_requests.push_back(fetch_req(11'h4D2, 1'b0));
    queued_requests.push_back(fetch_req(11'h4D2, 1'b1));
    r = store_req(11'h0F0, 4'd15, {$urandom, $urandom}, '0);
    r.any = 1'b1;
    queued_requests.push_back(r);
    queued_requests.push_back(fetch_req(11'h155, 1'b0));

    // random: fill-heavy, drain-heavy and mixed phases over a small id pool
    made = 0;
    stamp_clock = 32'd1000;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       store_pct = 80;
        1:       store_pct = 25;
        default: store_pct = 50;
      endcase
      for (int p = 0; p < 6; p++) id_pool[p] = rfs_pkg::IdW'($urandom_range(0, 2047));
      for (int j = 0; j < phase_len && made < RANDOM_ITEMS; j++) begin
        if ($urandom_range(0, 99) < 75) fid = id_pool[$urandom_range(0, 5)];
        else                            fid = rfs_pkg::IdW'($urandom_range(0, 2047));
        if ($urandom_range(0, 99) < store_pct) begin
          sel = $urandom_range(0, 9);
          if (sel < 6) begin
            stamp_clock += $urandom_range(1, 500);
            stamp = stamp_clock;
          end else if (sel < 8) begin
            stamp = stamp_clock - $urandom_range(0, 3);
          end else begin
            stamp = $urandom;
          end
          if ($urandom_range(0, 9) < 8) len = rfs_pkg::LenW'($urandom_range(0, 8));
          else                          len = rfs_pkg::LenW'($urandom_range(9, 15));
          r = store_req(fid, len, {$urandom, $urandom}, stamp);
          r.any = 1'($urandom_range(0, 1));
        end else begin
          r = fetch_req(fid, $urandom_range(0, 99) < 30);
        end
        queued_requests.push_back(r);
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (queued_requests.size() > 0 || loaded || awaited_replies.size() > 0)
      @(posedge clk);
    repeat (3 * (NSLOTS + 3)) @(posedge clk);

    $display("tb: %0d stores with %0d evictions, %0d fetches with %0d hits",
             store_total, evict_total, fetch_total, hit_total);
    $display("tb: %0d mismatched transactions", mismatch_total);
    if (mismatch_total == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
